// ===== hw/rtl/laplacian_sharpen_stream_macros.svh =====
// Assertion macros for the checker file of the sharpening block.
// The enclosing scope must provide clk and rst (synchronous, active high).
`ifndef LAPLACIAN_SHARPEN_STREAM_MACROS_SVH
`define LAPLACIAN_SHARPEN_STREAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lss_pkg.sv =====
// Shared constants, register codes and inter-stage structs for the
// Laplacian sharpening stream. No dependencies.
package lss_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 3;
  localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;

  localparam int SAMPLE_W    = 8;
  localparam int ROW_W       = 12;
  localparam int INDEX_W     = 13;
  localparam int CFG_W       = 12;
  localparam int CHAN_W      = 2;
  localparam int OUT_FIELD_W = SAMPLE_W + ROW_W + INDEX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]  WIDTH_RESET    = 12'd640;
  localparam logic [CFG_W-1:0]  HEIGHT_RESET   = 12'd480;
  localparam logic [CHAN_W-1:0] CHANNELS_RESET = 2'd1;
  localparam logic [CFG_W-1:0]  MIN_DIM        = 12'd3;

  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_index_t;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } out_phase_t;

  // One accepted item with its position and border flags.
  typedef struct packed {
    logic [INDEX_W-1:0]  s;
    logic [ROW_W-1:0]    r;
    logic [SAMPLE_W-1:0] x;
    logic                emit;
    logic                inner;
    logic                last_row;
    logic                frame_end;
  } issue_t;

  // Result pair handed to the output stage.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]    orow;
    logic [INDEX_W-1:0]  index;
    logic                last_row;
    logic                frame_end;
  } result_t;

endpackage

// ===== hw/rtl/lss_ram.sv =====
// Generic synchronous RAM: one write port, two read ports with enable,
// registered read data. No dependencies.
module lss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== hw/rtl/lss_ctrl.sv =====
// Configuration registers, raster counters and line store addressing.
// Depends on lss_pkg.
module lss_ctrl import lss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                accept,
  input  logic [SAMPLE_W-1:0] sample_in,
  output issue_t              issue,
  output logic [INDEX_W-1:0]  addr_center,
  output logic [INDEX_W-1:0]  addr_right,
  output logic [INDEX_W-1:0]  addr_left
);

  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [CHAN_W-1:0]  channel_count;
  logic [INDEX_W-1:0] sample_counter;
  logic [ROW_W-1:0]   row_counter;

  logic [CFG_W-1:0]   w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic [CHAN_W-1:0]  c_eff;
  logic [INDEX_W-1:0] c_step;
  logic [INDEX_W-1:0] row_len;
  logic               row_done;
  logic               inner;
  logic               cfg_hit;

  always_comb begin
    if (image_width < MIN_DIM) begin
      w_eff = MIN_DIM;
    end else if (image_width > CFG_W'(MAX_WIDTH)) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height < MIN_DIM) ? MIN_DIM : image_height;
    if (channel_count == '0) begin
      c_eff = CHAN_W'(1);
    end else if (channel_count > CHAN_W'(MAX_CHANNELS)) begin
      c_eff = CHAN_W'(MAX_CHANNELS);
    end else begin
      c_eff = channel_count;
    end
  end

  assign c_step   = INDEX_W'(c_eff);
  assign row_len  = INDEX_W'(w_eff) * c_step;
  assign row_done = (sample_counter == row_len - INDEX_W'(1));

  // Inner sample: output row away from top border, pixel away from both sides.
  assign inner = (row_counter >= ROW_W'(2)) && (sample_counter >= c_step) &&
                 (sample_counter < row_len - c_step);

  always_comb begin
    issue.s         = sample_counter;
    issue.r         = row_counter;
    issue.x         = sample_in;
    issue.emit      = (row_counter != '0);
    issue.inner     = inner;
    issue.last_row  = (row_counter == h_eff - ROW_W'(1));
    issue.frame_end = row_done;
  end

  assign addr_center = sample_counter;
  assign addr_right  = inner ? sample_counter + c_step : '0;
  assign addr_left   = inner ? sample_counter - c_step : '0;

  always_comb begin
    case (cfg_index)
      CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      channel_count <= CHANNELS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:    image_width   <= cfg_data;
        CFG_HEIGHT:   image_height  <= cfg_data;
        CFG_CHANNELS: channel_count <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      // restart the frame on a width, height or channels write
      sample_counter <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      if (row_done) begin
        sample_counter <= '0;
        row_counter    <= (row_counter == h_eff - ROW_W'(1)) ? '0
                                                              : row_counter + ROW_W'(1);
      end else begin
        sample_counter <= sample_counter + INDEX_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lss_calc.sv =====
// Read-modify-write stage: takes line store read data, computes the
// clamped 5-point value and writes both line stores back. Depends on lss_pkg.
module lss_calc import lss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  issue_t              issue,
  input  logic [INDEX_W-1:0]  addr_left,
  input  logic [SAMPLE_W-1:0] newer_q_a,
  input  logic [SAMPLE_W-1:0] newer_q_b,
  input  logic [SAMPLE_W-1:0] older_q_a,
  input  logic [SAMPLE_W-1:0] older_q_b,
  input  logic                out_free,
  output logic                in_ready,
  output logic                wr_en,
  output logic [INDEX_W-1:0]  wr_addr,
  output logic [SAMPLE_W-1:0] older_wr_data,
  output logic [SAMPLE_W-1:0] newer_wr_data,
  output logic                res_load,
  output result_t             res
);

  logic                a_valid;
  issue_t              a_item;
  logic                fwd;
  logic [SAMPLE_W-1:0] fwd_data;
  logic                a_move;

  logic [SAMPLE_W-1:0] left;
  logic [10:0]         centre5;
  logic [9:0]          neigh;
  logic signed [11:0]  diff;
  logic [SAMPLE_W-1:0] clamped;

  assign a_move   = a_valid && (!a_item.emit || out_free);
  assign in_ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  // The left neighbour may be the entry written back at this very edge;
  // forward it instead of trusting the RAM read.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item   <= issue;
      fwd      <= a_move && (addr_left == a_item.s);
      fwd_data <= newer_q_a;
    end
  end

  assign left    = fwd ? fwd_data : older_q_b;
  assign centre5 = {1'b0, newer_q_a, 2'b00} + {3'b000, newer_q_a};
  assign neigh   = {2'b00, older_q_a} + {2'b00, a_item.x} +
                   {2'b00, left} + {2'b00, newer_q_b};
  assign diff    = $signed({1'b0, centre5}) - $signed({2'b00, neigh});

  always_comb begin
    if (diff[11]) begin
      clamped = '0;
    end else if (diff[10:8] != 3'b000) begin
      clamped = '1;
    end else begin
      clamped = diff[7:0];
    end
  end

  always_comb begin
    res.value     = a_item.inner ? clamped : '0;
    res.orow      = a_item.r - ROW_W'(1);
    res.index     = a_item.s;
    res.last_row  = a_item.last_row;
    res.frame_end = a_item.frame_end;
  end

  assign res_load      = a_move && a_item.emit;
  assign wr_en         = a_move;
  assign wr_addr       = a_item.s;
  assign older_wr_data = newer_q_a;
  assign newer_wr_data = a_item.x;

endmodule

// ===== hw/rtl/lss_out.sv =====
// Output register: holds one result pair and sends it as one or two items.
// Depends on lss_pkg.
module lss_out import lss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_load,
  input  result_t                res,
  input  logic                   m_axis_tready,
  output logic                   out_free,
  output logic                   m_axis_tvalid,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser
);

  logic       b_valid;
  result_t    b_res;
  out_phase_t phase;
  out_phase_t phase_next;
  logic       taken;
  logic       done;

  logic [SAMPLE_W-1:0] sample_out;
  logic [ROW_W-1:0]    out_row;

  assign taken    = b_valid && m_axis_tready;
  assign done     = taken && ((phase == PH_SECOND) || !b_res.last_row);
  assign out_free = !b_valid || done;

  always_comb begin
    phase_next = phase;
    if (res_load) begin
      phase_next = PH_FIRST;
    end else if (taken) begin
      case (phase)
        PH_FIRST:  phase_next = b_res.last_row ? PH_SECOND : PH_FIRST;
        PH_SECOND: phase_next = PH_FIRST;
        default:   phase_next = PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      phase   <= PH_FIRST;
    end else begin
      phase <= phase_next;
      if (res_load) begin
        b_valid <= 1'b1;
      end else if (done) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      b_res <= res;
    end
  end

  // Second item of a pair: the zero border sample of the last row itself.
  always_comb begin
    case (phase)
      PH_FIRST: begin
        sample_out   = b_res.value;
        out_row      = b_res.orow;
        m_axis_tlast = !b_res.last_row;
        m_axis_tuser = 1'b0;
      end
      PH_SECOND: begin
        sample_out   = '0;
        out_row      = b_res.orow + ROW_W'(1);
        m_axis_tlast = 1'b1;
        m_axis_tuser = b_res.frame_end;
      end
      default: begin
        sample_out   = '0;
        out_row      = '0;
        m_axis_tlast = 1'b0;
        m_axis_tuser = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), b_res.index, out_row, sample_out};

endmodule

// ===== hw/rtl/laplacian_sharpen_stream.sv =====
// Top level of the 5-point Laplacian sharpening stream.
// Depends on lss_pkg, lss_ram, lss_ctrl, lss_calc and lss_out.
//
// Takes one 8-bit sample per clock in raster order (1 to 3 interleaved
// channels) while the output does not stall, and returns 5*centre - up -
// down - left - right clamped to 0..255, zero on the border rows and pixel
// columns. Results lag the input by one row: an item in row r (r >= 1)
// gives the result for row r-1 through the calc and output registers; row
// 0 items give none. In the last row every item gives two results (the row
// above plus a zero for the last row), so the single output port slows the
// input there; elsewhere it is one item per cycle. Two 6144 x 8 line
// stores, each with one write and two read ports, hold the previous two
// rows and are read and written back once per item. A width, height or
// channels write restarts the frame at row 0; line stores need no clearing.
module laplacian_sharpen_stream import lss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [7:0] sample_in
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] sample_out, [19:8] out_row,
                                                 // [32:20] out_index, rest zero
  output logic                   m_axis_tlast,   // last_of_run
  output logic                   m_axis_tuser,   // [0] frame_end
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic                accept;
  issue_t              issue;
  logic [INDEX_W-1:0]  addr_center;
  logic [INDEX_W-1:0]  addr_right;
  logic [INDEX_W-1:0]  addr_left;
  logic [SAMPLE_W-1:0] newer_q_a;
  logic [SAMPLE_W-1:0] newer_q_b;
  logic [SAMPLE_W-1:0] older_q_a;
  logic [SAMPLE_W-1:0] older_q_b;
  logic                out_free;
  logic                wr_en;
  logic [INDEX_W-1:0]  wr_addr;
  logic [SAMPLE_W-1:0] older_wr_data;
  logic [SAMPLE_W-1:0] newer_wr_data;
  logic                res_load;
  result_t             res;

  assign accept = s_axis_tvalid && s_axis_tready;

  lss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .sample_in   (s_axis_tdata),
    .issue       (issue),
    .addr_center (addr_center),
    .addr_right  (addr_right),
    .addr_left   (addr_left)
  );

  // Row two back: up at s, left at s - channels.
  lss_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_older_line (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (older_wr_data),
    .rd_en     (accept),
    .rd_addr_a (addr_center),
    .rd_addr_b (addr_left),
    .rd_data_a (older_q_a),
    .rd_data_b (older_q_b)
  );

  // Previous row: centre at s, right at s + channels.
  lss_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_newer_line (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (newer_wr_data),
    .rd_en     (accept),
    .rd_addr_a (addr_center),
    .rd_addr_b (addr_right),
    .rd_data_a (newer_q_a),
    .rd_data_b (newer_q_b)
  );

  lss_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .issue         (issue),
    .addr_left     (addr_left),
    .newer_q_a     (newer_q_a),
    .newer_q_b     (newer_q_b),
    .older_q_a     (older_q_a),
    .older_q_b     (older_q_b),
    .out_free      (out_free),
    .in_ready      (s_axis_tready),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .older_wr_data (older_wr_data),
    .newer_wr_data (newer_wr_data),
    .res_load      (res_load),
    .res           (res)
  );

  lss_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res_load      (res_load),
    .res           (res),
    .m_axis_tready (m_axis_tready),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hw/rtl/lss_check.sv =====
// Port-level checker for the sharpening stream, bound to the top level.
// Depends on lss_pkg and laplacian_sharpen_stream_macros.svh.
`include "laplacian_sharpen_stream_macros.svh"

module lss_check import lss_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser
);

  // Frame end only ever marks the zero item that closes a pair.
  `LSS_ASSERT_NOW(a_fend_closes_run, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata[7:0] == 8'd0), "frame end on a non-final or non-zero item")

  // A non-final item is followed at once by the last-row zero at the same index.
  `LSS_ASSERT_NEXT(a_pair_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && (m_axis_tdata[7:0] == 8'd0), "second item of a pair missing")

  `LSS_ASSERT_NEXT(a_pair_position, m_axis_tvalid && m_axis_tready && !m_axis_tlast, (m_axis_tdata[32:20] == $past(m_axis_tdata[32:20])) && (m_axis_tdata[19:8] == $past(m_axis_tdata[19:8]) + 12'd1), "pair items not on adjacent rows at one index")

  // Pipeline is empty straight after reset.
  `LSS_ASSERT_NOW(a_ready_after_reset, $fell(rst), s_axis_tready && !m_axis_tvalid, "not idle after reset")

endmodule

bind laplacian_sharpen_stream lss_check u_check (.*);

// ===== verif/laplacian_sharpen_stream_tb.sv =====
// Self-checking testbench for laplacian_sharpen_stream: a scoreboard class predicts each
// sharpened sample from its own copy of the line stores and counters and checks every result.
// Depends on lss_pkg and the RTL of the block only.
module laplacian_sharpen_stream_tb;
  import lss_pkg::*;

  localparam int MAX_ROWS     = 4095;
  localparam int MAX_GAP      = 19;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 575;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef enum {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} idle_style_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [ROW_W-1:0]    row;
    logic [INDEX_W-1:0]  pos;
    logic                run_end;
    logic                frame_end;
  } sharp_result_t;

  class sharpen_scoreboard;
    int unsigned   width_reg, height_reg, chan_reg;
    int unsigned   row_pos, sample_pos;
    bit [7:0]      older_row [LINE_DEPTH];
    bit [7:0]      newer_row [LINE_DEPTH];
    sharp_result_t sharpened_q[$];
    int unsigned   mismatches;

    function new();
      width_reg  = 32'(WIDTH_RESET);
      height_reg = 32'(HEIGHT_RESET);
      chan_reg   = 32'(CHANNELS_RESET);
      row_pos    = 0;
      sample_pos = 0;
      mismatches = 0;
    endfunction

    function int unsigned line_slot(int unsigned i);
      return (i < LINE_DEPTH) ? i : 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_WIDTH:    width_reg = 32'(value);
        CFG_HEIGHT:   height_reg = 32'(value);
        CFG_CHANNELS: chan_reg = 32'(value[CHAN_W-1:0]);
        default:      return;
      endcase
      row_pos    = 0;
      sample_pos = 0;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] x);
      int unsigned w, h, c, row_len, s, r, orow, pix;
      int          up, centre, left, right, below, v;
      bit          last_row;
      w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < 3) ? 3 : (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
      c = (chan_reg < 1) ? 1 : (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg;
      row_len = w * c;
      s = (sample_pos >= row_len) ? 0 : sample_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      last_row = (r == h - 1);
      below  = 32'(x);
      up     = 32'(older_row[line_slot(s)]);
      centre = 32'(newer_row[line_slot(s)]);
      if (r >= 1) begin
        orow = r - 1;
        pix  = s / c;
        v    = 0;
        if (orow >= 1 && orow <= h - 2 && pix >= 1 && pix <= w - 2) begin
          // older row already holds the left neighbour, newer row the right one
          left  = 32'(older_row[line_slot(s - c)]);
          right = 32'(newer_row[line_slot(s + c)]);
          v = 5 * centre - up - below - left - right;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        sharpened_q.push_back('{level: v[7:0], row: orow[ROW_W-1:0],
                                pos: s[INDEX_W-1:0], run_end: !last_row, frame_end: 1'b0});
        if (last_row)
          sharpened_q.push_back('{level: '0, row: r[ROW_W-1:0], pos: s[INDEX_W-1:0],
                                  run_end: 1'b1, frame_end: (s == row_len - 1)});
      end
      older_row[line_slot(s)] = 8'(centre);
      newer_row[line_slot(s)] = x;
      s++;
      if (s >= row_len) begin
        s = 0;
        r++;
        if (r >= h) r = 0;
      end
      sample_pos = s;
      row_pos    = r;
    endfunction

    function void flag(string what, sharp_result_t want, sharp_result_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%s: expected value %0d row %0d index %0d last %0b fend %0b,",
                 what, want.level, want.row, want.pos, want.run_end, want.frame_end,
                 " got value %0d row %0d index %0d last %0b fend %0b",
                 got.level, got.row, got.pos, got.run_end, got.frame_end);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last, logic user);
      sharp_result_t want, got;
      got = '{level: data[7:0], row: data[19:8], pos: data[32:20], run_end: last,
              frame_end: user};
      if (sharpened_q.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = sharpened_q.pop_front();
      if (got !== want || data[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
        flag("result mismatch", want, got);
    endfunction

    function int unsigned pending();
      return sharpened_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAMPLE_W-1:0]    s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  sharpen_scoreboard sb;
  idle_style_t       in_idle = IDLE_NONE;
  idle_style_t       out_idle = IDLE_NONE;
  int                hold_left = 0;
  int unsigned       cur_w = 640, cur_h = 480, cur_c = 1;

  laplacian_sharpen_stream dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_wait(idle_style_t style);
    case (style)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, MAX_GAP);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2, 3:    return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic idle_style_t pick_idle();
    case ($urandom_range(0, 2))
      0:       return IDLE_NONE;
      1:       return IDLE_FULL;
      default: return IDLE_LIGHT;
    endcase
  endfunction

  // Result side: check each item, then hold tready low for a drawn stall.
  always @(posedge clk) begin
    int stall;
    if (!rst) begin
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        stall = draw_wait(out_idle);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          hold_left <= stall;
        end
      end else if (!m_axis_tready) begin
        if (hold_left <= 1) m_axis_tready <= 1'b1;
        hold_left <= hold_left - 1;
      end
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] x);
    int gap;
    gap = draw_wait(in_idle);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_sample(x);
  endtask

  task automatic feed_random(input int count);
    for (int i = 0; i < count; i++) push_sample(pick_sample());
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.note_config(idx, value);
  endtask

  task automatic set_up(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                        input logic [CHAN_W-1:0] c, input bit [2:0] mask, input bit spare);
    if (spare) write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 4095)));
    if (mask[0]) write_reg(CFG_WIDTH, w);
    if (mask[1]) write_reg(CFG_HEIGHT, h);
    if (mask[2]) write_reg(CFG_CHANNELS, c);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int done_items, count, frame, we, he, ce;
    bit [2:0] mask;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: one full row and a little of the next
    in_idle  = IDLE_LIGHT;
    out_idle = IDLE_LIGHT;
    feed_random(650);
    settle();

    // smallest frame: clamp high, clamp low, then a partial frame of rising values
    set_up(12'd3, 12'd3, 2'd1, 3'b111, 1'b0);
    for (int i = 0; i < 9; i++) push_sample((i == 4) ? 8'd255 : 8'd0);
    for (int i = 0; i < 9; i++) push_sample((i == 4) ? 8'd0 : 8'd255);
    for (int i = 0; i < 7; i++) push_sample(8'(10 * (i + 1)));
    settle();

    // tallest frame, only its first rows
    in_idle  = IDLE_NONE;
    out_idle = IDLE_FULL;
    set_up(12'd3, 12'd4095, 2'd1, 3'b111, 1'b1);
    feed_random(60);
    settle();

    // width above the limit clamps to the widest row, so a short run stays in row zero
    in_idle  = IDLE_FULL;
    out_idle = IDLE_NONE;
    set_up(12'd4095, 12'd1, 2'd1, 3'b111, 1'b0);
    feed_random(40);
    settle();

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      mask = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b111;
      if (mask[0]) begin
        case ($urandom_range(0, 19))
          0, 1, 2: cur_w = $urandom_range(0, 2);
          3, 4, 5: cur_w = $urandom_range(11, 40);
          default: cur_w = $urandom_range(3, 10);
        endcase
      end
      if (mask[1]) cur_h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                                        : $urandom_range(3, 7);
      if (mask[2]) cur_c = $urandom_range(0, 3);
      in_idle  = pick_idle();
      out_idle = pick_idle();
      set_up(CFG_W'(cur_w), CFG_W'(cur_h), CHAN_W'(cur_c), mask, $urandom_range(0, 5) == 0);
      we = (cur_w < 3) ? 3 : cur_w;
      he = (cur_h < 3) ? 3 : cur_h;
      ce = (cur_c < 1) ? 1 : cur_c;
      frame = we * ce * he;
      count = frame * $urandom_range(1, 2) + $urandom_range(0, frame);
      if (count > 450) count = 450;
      if (count > RANDOM_ITEMS - done_items) count = RANDOM_ITEMS - done_items;
      feed_random(count);
      done_items += count;
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
